[hw/rtl/octilinear_line_plotter_defines.svh]
// ----------------------------------------------------------------------------
// Octilinear line plotter assertion macros
// Shared property wrappers for the checker.
// ----------------------------------------------------------------------------
`ifndef OCTILINEAR_LINE_PLOTTER_DEFINES_SVH
`define OCTILINEAR_LINE_PLOTTER_DEFINES_SVH

// Same-cycle implication, off during reset
`define OLP_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("olp check failed");

// Next-cycle implication, off during reset
`define OLP_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("olp check failed");

// Next-cycle implication that also holds across reset
`define OLP_ASSERT_RST(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("olp reset check failed");

`endif

[hw/rtl/olp_pkg.sv]
// ----------------------------------------------------------------------------
// olp_pkg
// Types, codes and helpers shared by the octilinear line plotter modules.
// ----------------------------------------------------------------------------
package olp_pkg;

  localparam int GRID_DEFAULT = 128;
  localparam int COORD_W      = 7;
  localparam int COUNT_W      = 16;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Input item operation codes
  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_DRAW  = 2'd1,
    OP_READ  = 2'd2,
    OP_NOP   = 2'd3
  } op_e_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic clr_wr;      // write zero at clear pointer, advance it
    logic load_item;   // capture input item
    logic start_plot;  // begin stroke, plot its point
    logic draw_begin;  // segment ok: bump point count, cursor at last point
    logic draw_fail;   // segment bad: bump point count, set sticky error
    logic draw_step;   // plot cursor pixel, step or finish
    logic read_issue;  // launch canvas read
    logic resp_load;   // load output register
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic op_start;
    logic op_draw;
    logic op_read;
    logic err;
    logic oct_ok;
    logic at_target;
    logic clr_done;
    logic out_free;
  } sts_t;

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
    return (v == COUNT_MAX) ? COUNT_MAX : v + 1'b1;
  endfunction

  function automatic logic [COORD_W-1:0] abs_diff(input logic [COORD_W-1:0] a,
                                                  input logic [COORD_W-1:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

endpackage

[hw/rtl/olp_ram.sv]
// ----------------------------------------------------------------------------
// olp_ram
// Simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module olp_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hw/rtl/olp_ctrl.sv]
// ----------------------------------------------------------------------------
// olp_ctrl
// Sequencer: canvas clear, item decode, segment walk, read and response.
// ----------------------------------------------------------------------------
module olp_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  olp_pkg::sts_t sts,
  output olp_pkg::cmd_t cmd
);
  import olp_pkg::*;

  typedef enum logic [5:0] {
    S_CLEAR  = 6'b000001,
    S_IDLE   = 6'b000010,
    S_EXEC   = 6'b000100,
    S_DRAW   = 6'b001000,
    S_RDWAIT = 6'b010000,
    S_RESP   = 6'b100000
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE);

  // Next state and command decode
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next    = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts.op_start && !sts.err) begin
          cmd.start_plot = 1'b1;
          state_next     = S_RESP;
        end else if (sts.op_draw && !sts.err) begin
          if (sts.oct_ok) begin
            cmd.draw_begin = 1'b1;
            state_next     = S_DRAW;
          end else begin
            cmd.draw_fail = 1'b1;
            state_next    = S_RESP;
          end
        end else if (sts.op_read) begin
          cmd.read_issue = 1'b1;
          state_next     = S_RDWAIT;
        end else begin
          state_next = S_RESP;
        end
      end
      S_DRAW: begin
        cmd.draw_step = 1'b1;
        if (sts.at_target) state_next = S_RESP;
      end
      S_RDWAIT: begin
        state_next = S_RESP;
      end
      S_RESP: begin
        if (sts.out_free) begin
          cmd.resp_load = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule

[hw/rtl/olp_dp.sv]
// ----------------------------------------------------------------------------
// olp_dp
// Datapath: item register, stroke state, segment cursor, canvas RAM and
// output register.
// ----------------------------------------------------------------------------
module olp_dp #(
  parameter int GRID = olp_pkg::GRID_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [1:0]                  op,
  input  logic [olp_pkg::COORD_W-1:0] px,
  input  logic [olp_pkg::COORD_W-1:0] py,
  input  olp_pkg::cmd_t               cmd,
  output olp_pkg::sts_t               sts,
  input  logic                        out_ready,
  output logic                        out_valid,
  output logic                        status,
  output logic [olp_pkg::COUNT_W-1:0] stroke_number,
  output logic [olp_pkg::COUNT_W-1:0] point_number,
  output logic                        pixel
);
  import olp_pkg::*;

  localparam int DEPTH = GRID * GRID;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [AW-1:0] GRID_A = AW'(GRID);
  localparam logic [AW-1:0] LAST_A = AW'(DEPTH - 1);

  op_e_t              item_op;
  logic [COORD_W-1:0] item_x, item_y;
  logic [COORD_W-1:0] last_x, last_y;
  logic [COORD_W-1:0] cur_x, cur_y;
  logic [COUNT_W-1:0] stroke_cnt, point_cnt;
  logic               err;
  logic               pix_sel;
  logic [AW-1:0]      clr_cnt;

  logic [COORD_W-1:0] dx, dy;
  logic               item_in, cur_in;
  logic [AW-1:0]      item_addr, cur_addr;
  logic               ram_we, ram_wdata, ram_rdata;
  logic [AW-1:0]      ram_waddr;

  // Grid bounds and canvas addresses
  assign item_in   = (32'(item_x) < 32'(GRID)) && (32'(item_y) < 32'(GRID));
  assign cur_in    = (32'(cur_x) < 32'(GRID)) && (32'(cur_y) < 32'(GRID));
  assign item_addr = AW'(item_x) * GRID_A + AW'(item_y);
  assign cur_addr  = AW'(cur_x) * GRID_A + AW'(cur_y);

  // Segment direction check against the previous point
  assign dx = abs_diff(last_x, item_x);
  assign dy = abs_diff(last_y, item_y);

  // Status to controller
  always_comb begin
    sts           = '0;
    sts.op_start  = (item_op == OP_START);
    sts.op_draw   = (item_op == OP_DRAW);
    sts.op_read   = (item_op == OP_READ);
    sts.err       = err;
    sts.oct_ok    = (dx == '0) || (dy == '0) || (dx == dy);
    sts.at_target = (cur_x == item_x) && (cur_y == item_y);
    sts.clr_done  = (clr_cnt == LAST_A);
    sts.out_free  = !out_valid || out_ready;
  end

  // Canvas write port: clear pass, start point, segment pixels
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cur_addr;
    ram_wdata = 1'b1;
    if (cmd.clr_wr) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt;
      ram_wdata = 1'b0;
    end else if (cmd.start_plot) begin
      ram_we    = item_in;
      ram_waddr = item_addr;
    end else if (cmd.draw_step) begin
      ram_we    = cur_in;
    end
  end

  olp_ram #(
    .WIDTH (1),
    .DEPTH (DEPTH)
  ) u_canvas (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.read_issue),
    .raddr (item_addr),
    .rdata (ram_rdata)
  );

  // Stroke state, clear pointer and output handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      last_x     <= '0;
      last_y     <= '0;
      stroke_cnt <= '0;
      point_cnt  <= '0;
      err        <= 1'b0;
      clr_cnt    <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.clr_wr) clr_cnt <= clr_cnt + 1'b1;
      if (cmd.start_plot) begin
        stroke_cnt <= sat_inc(stroke_cnt);
        point_cnt  <= COUNT_W'(1);
        last_x     <= item_x;
        last_y     <= item_y;
      end
      if (cmd.draw_begin) point_cnt <= sat_inc(point_cnt);
      if (cmd.draw_fail) begin
        point_cnt <= sat_inc(point_cnt);
        err       <= 1'b1;
      end
      if (cmd.draw_step && sts.at_target) begin
        last_x <= item_x;
        last_y <= item_y;
      end
      if (cmd.resp_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Item register, segment cursor and result payload
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_op <= op_e_t'(op);
      item_x  <= px;
      item_y  <= py;
      pix_sel <= 1'b0;
    end
    if (cmd.read_issue) pix_sel <= item_in;
    if (cmd.draw_begin) begin
      cur_x <= last_x;
      cur_y <= last_y;
    end else if (cmd.draw_step) begin
      if (item_x > cur_x) cur_x <= cur_x + 1'b1;
      else if (item_x < cur_x) cur_x <= cur_x - 1'b1;
      if (item_y > cur_y) cur_y <= cur_y + 1'b1;
      else if (item_y < cur_y) cur_y <= cur_y - 1'b1;
    end
    if (cmd.resp_load) begin
      status        <= err;
      stroke_number <= stroke_cnt;
      point_number  <= point_cnt;
      pixel         <= pix_sel & ram_rdata;
    end
  end

endmodule

[hw/rtl/octilinear_line_plotter.sv]
// Sequence: a start, a skipped item, a bad segment or an unused op goes from the execute state
// to the response state; a read adds a wait state for the canvas read; an octilinear segment
// is walked one pixel per cycle in the draw state first. The response state waits for a free
// output register. Throughput: one item at a time, the next accepted once the sequencer is
// back in idle. Reset: synchronous, then a clear pass zeroes the canvas RAM one pixel per
// cycle; in_ready stays low until it ends.
// ----------------------------------------------------------------------------
// octilinear_line_plotter
// Plots horizontal, vertical and 45-degree strokes into a one-bit canvas
// and reads back single pixels.
// ----------------------------------------------------------------------------
module octilinear_line_plotter #(
  parameter int GRID = olp_pkg::GRID_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  op,
  input  logic [olp_pkg::COORD_W-1:0] px,
  input  logic [olp_pkg::COORD_W-1:0] py,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        status,
  output logic [olp_pkg::COUNT_W-1:0] stroke_number,
  output logic [olp_pkg::COUNT_W-1:0] point_number,
  output logic                        pixel
);
  import olp_pkg::*;

  cmd_t cmd;
  sts_t sts;

  olp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  olp_dp #(
    .GRID (GRID)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .op            (op),
    .px            (px),
    .py            (py),
    .cmd           (cmd),
    .sts           (sts),
    .out_ready     (out_ready),
    .out_valid     (out_valid),
    .status        (status),
    .stroke_number (stroke_number),
    .point_number  (point_number),
    .pixel         (pixel)
  );

endmodule

[hw/rtl/olp_checker.sv]
// ----------------------------------------------------------------------------
// olp_checker
// Port-level checks for the octilinear line plotter, bound to the top level.
// ----------------------------------------------------------------------------
`include "octilinear_line_plotter_defines.svh"

module olp_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        status,
  input logic [olp_pkg::COUNT_W-1:0] stroke_number,
  input logic [olp_pkg::COUNT_W-1:0] point_number,
  input logic                        pixel
);

  logic err_seen;

  // Track whether an error result has been transferred
  always_ff @(posedge clk) begin
    if (rst) begin
      err_seen <= 1'b0;
    end else if (out_valid && out_ready && status) begin
      err_seen <= 1'b1;
    end
  end

  // Reset starts the clear pass with nothing pending
  `OLP_ASSERT_RST(a_reset_quiet, rst, !in_ready && !out_valid)

  // Only one item in flight
  `OLP_ASSERT_NXT(a_one_item, in_valid && in_ready, !in_ready)

  // Error status is sticky across results
  `OLP_ASSERT_IMP(a_err_sticky, out_valid && err_seen, status)

  // A stalled result holds
  `OLP_ASSERT_NXT(a_out_hold, out_valid && !out_ready,
                  out_valid && $stable(status) && $stable(stroke_number) &&
                  $stable(point_number) && $stable(pixel))

endmodule

bind octilinear_line_plotter olp_checker u_olp_checker (.*);
